// ===== src/ubdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubdc_pkg
// Shared types, constants and code mapping for the baud divisor calculator.
// ----------------------------------------------------------------------------
package ubdc_pkg;

  localparam int unsigned DIV_FIELD_MAX = 65535;
  localparam int unsigned NUM_MAX       = DIV_FIELD_MAX * 7;
  localparam int unsigned CLK_RESET     = 80000000;
  localparam int unsigned TOL_DIVISOR   = 100;

  // divider quotient/dividend register width and narrow-mode length
  localparam int unsigned DQ_W     = 64;
  localparam int unsigned DV_W     = 40;
  localparam int unsigned NARROW_W = 40;

  localparam logic [2:0] CODE_DIV1 = 3'h5;
  localparam logic [2:0] CODE_DIV2 = 3'h4;
  localparam logic [2:0] CODE_DIV3 = 3'h3;
  localparam logic [2:0] CODE_DIV4 = 3'h2;
  localparam logic [2:0] CODE_DIV5 = 3'h1;
  localparam logic [2:0] CODE_DIV6 = 3'h0;
  localparam logic [2:0] CODE_DIV7 = 3'h6;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WAIT,
    S_G1,
    S_G1R,
    S_N1R,
    S_D1R,
    S_MR,
    S_NR,
    S_SN,
    S_SD,
    S_PD,
    S_PDR,
    S_G2,
    S_G2R,
    S_TN,
    S_TD,
    S_MUL,
    S_EST,
    S_TOL,
    S_OUT
  } state_t;

  function automatic logic [2:0] prediv_code(input logic [2:0] d);
    logic [2:0] c;
    case (d)
      3'd1:    c = CODE_DIV1;
      3'd2:    c = CODE_DIV2;
      3'd3:    c = CODE_DIV3;
      3'd4:    c = CODE_DIV4;
      3'd5:    c = CODE_DIV5;
      3'd6:    c = CODE_DIV6;
      3'd7:    c = CODE_DIV7;
      default: c = CODE_DIV1;
    endcase
    return c;
  endfunction

endpackage

// ===== src/uart_baud_divisor_calculator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_calculator_unit
// Computes fractional baud divider settings with a shared bit-serial divider.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  input    | start / busy          | in_baud_rate
//  result   | out_valid (strobe)    | out_accepted, out_prediv_code,
//           |                       | out_increment_value, out_modulator_value
//  config   | cfg_valid / cfg_ready | cfg_source_clock_hz
//
// One transaction at a time. Each division runs 1 bit per cycle over 40
// quotient bits (64 for the final estimate). Two Euclid loops dominate
// the run time. A zero baud rate or a zero source clock is answered in
// the cycle after start. Reset is synchronous and sets the source clock
// to 80 MHz. The receiver cannot stall results.
module uart_baud_divisor_calculator_unit
  import ubdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_baud_rate,
  output logic        out_valid,
  output logic        out_accepted,
  output logic [2:0]  out_prediv_code,
  output logic [15:0] out_increment_value,
  output logic [15:0] out_modulator_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_source_clock_hz
);

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [31:0] clk_hz_r;
  logic [23:0] baud_r, baud_nxt;
  logic [35:0] a_r, a_nxt, b_r, b_nxt;
  logic [31:0] num_r, num_nxt, tnum_r, tnum_nxt;
  logic [27:0] den_r, den_nxt, mp_r, mp_nxt;
  logic [15:0] m_r, m_nxt;
  logic [2:0]  pd_r, pd_nxt;
  logic [35:0] tden_r, tden_nxt;
  logic [59:0] mc_r, mc_nxt, prod_r, prod_nxt;

  logic        ov_r, ov_nxt, oa_r, oa_nxt;
  logic [2:0]  oc_r, oc_nxt;
  logic [15:0] oi_r, oi_nxt, om_r, om_nxt;

  // serial divider
  logic [DQ_W-1:0] dq_r;
  logic [DV_W-1:0] rm_r, dv_r, dstep, dsub;
  logic [6:0]      dcnt_r;
  logic            dbusy_r, dge;
  logic            div_go, div_wide;
  logic [DQ_W-1:0] div_a;
  logic [DV_W-1:0] div_b;

  logic [59:0] est;
  logic [19:0] tol;
  logic [15:0] mx;

  assign dstep = {rm_r[DV_W-2:0], dq_r[DQ_W-1]};
  assign dge   = (dstep >= dv_r);
  assign dsub  = dstep - dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (div_go) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= div_wide ? 7'(DQ_W) : 7'(NARROW_W);
    end else if (dbusy_r) begin
      dcnt_r <= dcnt_r - 7'd1;
      if (dcnt_r == 7'd1) dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_go) begin
      dq_r <= div_wide ? div_a : (div_a << (DQ_W - NARROW_W));
      rm_r <= '0;
      dv_r <= div_b;
    end else if (dbusy_r) begin
      dq_r <= {dq_r[DQ_W-2:0], dge};
      rm_r <= dge ? dsub : dstep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      clk_hz_r <= 32'(CLK_RESET);
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) clk_hz_r <= cfg_source_clock_hz;
    end
  end

  always_ff @(posedge clk) begin
    baud_r <= baud_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    m_r    <= m_nxt;
    pd_r   <= pd_nxt;
    tnum_r <= tnum_nxt;
    tden_r <= tden_nxt;
    mc_r   <= mc_nxt;
    mp_r   <= mp_nxt;
    prod_r <= prod_nxt;
    oa_r   <= oa_nxt;
    oc_r   <= oc_nxt;
    oi_r   <= oi_nxt;
    om_r   <= om_nxt;
  end

  assign est = dq_r[59:0];
  assign tol = {1'b0, dq_r[17:0], 1'b0} + {2'b0, dq_r[17:0]};
  assign mx  = (m_r > (dq_r[15:0] + 16'd1)) ? m_r : (dq_r[15:0] + 16'd1);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    baud_nxt  = baud_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    m_nxt     = m_r;
    pd_nxt    = pd_r;
    tnum_nxt  = tnum_r;
    tden_nxt  = tden_r;
    mc_nxt    = mc_r;
    mp_nxt    = mp_r;
    prod_nxt  = prod_r;
    ov_nxt    = 1'b0;
    oa_nxt    = oa_r;
    oc_nxt    = oc_r;
    oi_nxt    = oi_r;
    om_nxt    = om_r;
    div_go    = 1'b0;
    div_wide  = 1'b0;
    div_a     = '0;
    div_b     = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          baud_nxt = in_baud_rate;
          if (in_baud_rate == 24'd0 || clk_hz_r == 32'd0) begin
            ov_nxt = 1'b1;
            oa_nxt = 1'b0;
            oc_nxt = '0;
            oi_nxt = '0;
            om_nxt = '0;
          end else begin
            a_nxt     = {4'b0, clk_hz_r};
            b_nxt     = {8'b0, in_baud_rate, 4'b0};
            state_nxt = S_G1;
          end
        end
      end
      S_WAIT: begin
        if (!dbusy_r) state_nxt = ret_r;
      end
      S_G1, S_G2: begin
        if (b_r == 36'd0) begin
          div_go    = 1'b1;
          div_a     = {32'b0, clk_hz_r};
          div_b     = {4'b0, a_r};
          ret_nxt   = (state_r == S_G1) ? S_N1R : S_TN;
          state_nxt = S_WAIT;
        end else begin
          div_go    = 1'b1;
          div_a     = {28'b0, a_r};
          div_b     = {4'b0, b_r};
          ret_nxt   = (state_r == S_G1) ? S_G1R : S_G2R;
          state_nxt = S_WAIT;
        end
      end
      S_G1R, S_G2R: begin
        a_nxt     = b_r;
        b_nxt     = rm_r[35:0];
        state_nxt = (state_r == S_G1R) ? S_G1 : S_G2;
      end
      S_N1R: begin
        num_nxt   = dq_r[31:0];
        div_go    = 1'b1;
        div_a     = {36'b0, baud_r, 4'b0};
        div_b     = {4'b0, a_r};
        ret_nxt   = S_D1R;
        state_nxt = S_WAIT;
      end
      S_D1R: begin
        den_nxt = dq_r[27:0];
        if (num_r > 32'(NUM_MAX) || dq_r[27:0] > 28'(DIV_FIELD_MAX)) begin
          div_go    = 1'b1;
          div_a     = {32'b0, num_r - 32'd1};
          div_b     = DV_W'(NUM_MAX);
          ret_nxt   = S_MR;
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_PD;
        end
      end
      S_MR: begin
        m_nxt     = dq_r[15:0] + 16'd1;
        div_go    = 1'b1;
        div_a     = {36'b0, den_r - 28'd1};
        div_b     = DV_W'(DIV_FIELD_MAX);
        ret_nxt   = S_NR;
        state_nxt = S_WAIT;
      end
      S_NR: begin
        // dq holds n - 1 here; compare against m using n
        m_nxt     = mx;
        div_go    = 1'b1;
        div_a     = {32'b0, num_r};
        div_b     = {24'b0, mx};
        ret_nxt   = S_SN;
        state_nxt = S_WAIT;
      end
      S_SN: begin
        num_nxt   = (dq_r[31:0] == 32'd0) ? 32'd1 : dq_r[31:0];
        div_go    = 1'b1;
        div_a     = {36'b0, den_r};
        div_b     = {24'b0, m_r};
        ret_nxt   = S_SD;
        state_nxt = S_WAIT;
      end
      S_SD: begin
        den_nxt   = (dq_r[27:0] == 28'd0) ? 28'd1 : dq_r[27:0];
        state_nxt = S_PD;
      end
      S_PD: begin
        div_go    = 1'b1;
        div_a     = {32'b0, num_r - 32'd1};
        div_b     = DV_W'(DIV_FIELD_MAX);
        ret_nxt   = S_PDR;
        state_nxt = S_WAIT;
      end
      S_PDR: begin
        pd_nxt    = dq_r[2:0] + 3'd1;
        a_nxt     = {4'b0, clk_hz_r};
        b_nxt     = {num_r, 4'b0};
        state_nxt = S_G2;
      end
      S_TN: begin
        tnum_nxt  = dq_r[31:0];
        div_go    = 1'b1;
        div_a     = {28'b0, num_r, 4'b0};
        div_b     = {4'b0, a_r};
        ret_nxt   = S_TD;
        state_nxt = S_WAIT;
      end
      S_TD: begin
        tden_nxt  = dq_r[35:0];
        mc_nxt    = {28'b0, tnum_r};
        mp_nxt    = den_r;
        prod_nxt  = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // shift-add multiply, one multiplier bit per cycle
        if (mp_r == 28'd0) begin
          div_go    = 1'b1;
          div_wide  = 1'b1;
          div_a     = {4'b0, prod_r};
          div_b     = {4'b0, tden_r};
          ret_nxt   = S_EST;
          state_nxt = S_WAIT;
        end else begin
          if (mp_r[0]) prod_nxt = prod_r + mc_r;
          mc_nxt = {mc_r[58:0], 1'b0};
          mp_nxt = {1'b0, mp_r[27:1]};
        end
      end
      S_EST: begin
        prod_nxt  = (est >= {36'b0, baud_r}) ? (est - {36'b0, baud_r})
                                            : ({36'b0, baud_r} - est);
        div_go    = 1'b1;
        div_a     = {40'b0, baud_r};
        div_b     = DV_W'(TOL_DIVISOR);
        ret_nxt   = S_TOL;
        state_nxt = S_WAIT;
      end
      S_TOL: begin
        if (prod_r < {40'b0, tol}) begin
          div_go    = 1'b1;
          div_a     = {32'b0, num_r};
          div_b     = {37'b0, pd_r};
          ret_nxt   = S_OUT;
          state_nxt = S_WAIT;
        end else begin
          ov_nxt    = 1'b1;
          oa_nxt    = 1'b0;
          oc_nxt    = '0;
          oi_nxt    = '0;
          om_nxt    = '0;
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        ov_nxt    = 1'b1;
        oa_nxt    = 1'b1;
        oc_nxt    = prediv_code(pd_r);
        oi_nxt    = den_r[15:0] - 16'd1;
        om_nxt    = dq_r[15:0] - 16'd1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy                = (state_r != S_IDLE);
  assign cfg_ready           = (state_r == S_IDLE);
  assign out_valid           = ov_r;
  assign out_accepted        = oa_r;
  assign out_prediv_code     = oc_r;
  assign out_increment_value = oi_r;
  assign out_modulator_value = om_r;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UART baud divisor calculator: directed and
// random baud requests across several source clocks, checked per transaction.
// ----------------------------------------------------------------------------
module testbench
  import ubdc_pkg::*;
();

  typedef struct packed {
    logic        accepted;
    logic [2:0]  code;
    logic [15:0] incr;
    logic [15:0] modv;
  } divisor_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [23:0] in_baud_rate = '0;
  logic        out_valid;
  logic        out_accepted;
  logic [2:0]  out_prediv_code;
  logic [15:0] out_increment_value;
  logic [15:0] out_modulator_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_source_clock_hz = '0;

  always #1 clk = ~clk;

  uart_baud_divisor_calculator_unit u_dut (.*);

  logic [23:0] pending_bauds[$];
  divisor_t    expected_divs[$];
  logic [31:0] model_clk_hz;
  int          idle_pct;
  int          errors;
  int          n_sent;
  int          n_checked;
  int          n_accepted;
  longint      cycle_count;

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic divisor_t compute_divisor(logic [31:0] src_hz, logic [23:0] baud_in);
    longint unsigned baud, clk_hz, fmax, num, den, g, divider, tnum, tden, est, diff;
    longint unsigned m, n, mx;
    divisor_t r;
    baud = 64'(baud_in);
    clk_hz = 64'(src_hz);
    fmax = 64'(DIV_FIELD_MAX);
    r = '0;
    if (baud == 0 || clk_hz == 0) return r;
    g = gcd64(clk_hz, baud << 4);
    num = clk_hz / g;
    den = (baud << 4) / g;
    if (num > fmax * 7 || den > fmax) begin
      m = (num - 1) / (fmax * 7) + 1;
      n = (den - 1) / fmax + 1;
      mx = (m > n) ? m : n;
      num = num / mx;
      den = den / mx;
      if (num == 0) num = 1;
      if (den == 0) den = 1;
    end
    divider = (num - 1) / fmax + 1;
    g = gcd64(clk_hz, num << 4);
    tnum = clk_hz / g;
    tden = (num << 4) / g;
    if (tden == 0) return r;
    est = (tnum * den) / tden;
    diff = (est >= baud) ? est - baud : baud - est;
    if (diff < (baud / TOL_DIVISOR) * 3) begin
      r.accepted = 1'b1;
      case (divider)
        1: r.code = CODE_DIV1;
        2: r.code = CODE_DIV2;
        3: r.code = CODE_DIV3;
        4: r.code = CODE_DIV4;
        5: r.code = CODE_DIV5;
        6: r.code = CODE_DIV6;
        7: r.code = CODE_DIV7;
        default: r.code = CODE_DIV1;
      endcase
      r.incr = 16'(den - 1);
      r.modv = 16'(num / divider - 1);
    end
    return r;
  endfunction

  // records acceptance at the rising edge for the driver
  logic start_taken = 1'b0;
  always @(posedge clk) begin
    start_taken <= start && !busy;
  end

  // driver: one request per transaction, random gaps
  always @(negedge clk) begin
    logic issue;
    issue = 1'b0;
    if (rst_n && !cfg_valid) begin
      if (!start || start_taken) begin
        if (pending_bauds.size() > 0 && $urandom_range(99, 0) >= idle_pct) issue = 1'b1;
        if (issue) begin
          in_baud_rate <= pending_bauds[0];
          expected_divs.push_back(compute_divisor(model_clk_hz, pending_bauds[0]));
          void'(pending_bauds.pop_front());
          n_sent <= n_sent + 1;
        end
        start <= issue;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    divisor_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      got = {out_accepted, out_prediv_code, out_increment_value, out_modulator_value};
      if (expected_divs.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors <= errors + 1;
      end else begin
        want = expected_divs.pop_front();
        n_checked <= n_checked + 1;
        if (want.accepted) n_accepted <= n_accepted + 1;
        if (got !== want) begin
          $display({"%0t: mismatch baud result: expected acc=%0d code=%0d inc=%0d",
                    " mod=%0d, actual acc=%0d code=%0d inc=%0d mod=%0d"},
                   $time, want.accepted, want.code, want.incr, want.modv,
                   got.accepted, got.code, got.incr, got.modv);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic drain();
    while (pending_bauds.size() > 0 || start || expected_divs.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_clock(logic [31:0] hz);
    @(negedge clk);
    cfg_source_clock_hz <= hz;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    model_clk_hz = hz;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_batch(int count);
    int sel;
    repeat (count) begin
      sel = $urandom_range(9, 0);
      if (sel < 5) pending_bauds.push_back(24'($urandom_range(3000000, 100)));
      else if (sel < 7) pending_bauds.push_back(24'($urandom));
      else if (sel < 8) pending_bauds.push_back(24'($urandom_range(120, 0)));
      else begin
        case ($urandom_range(4, 0))
          0: pending_bauds.push_back(24'd9600);
          1: pending_bauds.push_back(24'd115200);
          2: pending_bauds.push_back(24'd921600);
          3: pending_bauds.push_back(24'd38400);
          default: pending_bauds.push_back(24'd1200);
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    if (cycle_count > 64'd3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [31:0] clocks[6];
    int idles[4];
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_accepted = 0;
    cycle_count = 0;
    idle_pct = 0;
    model_clk_hz = CLK_RESET;
    clocks = '{32'd80000000, 32'd1, 32'hFFFFFFFF, 32'd0, 32'd1843200, 32'd48000000};
    idles = '{0, 60, 19, 0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset clock, field extremes, low and standard rates
    pending_bauds = '{24'd0, 24'd1, 24'd99, 24'd100, 24'd101, 24'hFFFFFF,
                      24'h800000, 24'h7FFFFF, 24'h555555, 24'hAAAAAA,
                      24'd9600, 24'd115200, 24'd300, 24'd5000000};
    drain();
    for (int p = 0; p < 6; p++) begin
      write_clock((p == 0) ? 32'($urandom) : clocks[p]);
      idle_pct = idles[p % 4];
      if (p == 3) pending_bauds = '{24'd9600, 24'd0};
      random_batch(25);
      drain();
    end
    write_clock(CLK_RESET);
    random_batch(10);
    drain();

    $display("covered %0d requests over 7 source clocks, %0d checked, %0d accepted",
             n_sent, n_checked, n_accepted);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
